/* sv/ifd_pkg.sv */
// ---------------------------------------------------------------------------
// ifd_pkg
// Shared types and constants of the interpolated feedback delay.
// ---------------------------------------------------------------------------
`default_nettype none

package ifd_pkg;

    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_DELAY = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 4'd1;

    localparam logic [15:0] DELAY_RESET = 16'd24000;
    localparam logic [15:0] GAIN_RESET  = 16'd0;
    localparam logic [15:0] GAIN_CAP    = 16'd64880;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADDR,
        S_MUL,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [15:0] delay_samples;
        logic [15:0] feedback_gain;
    } t_cfg;

endpackage

`default_nettype wire

/* sv/ifd_in_if.sv */
// ---------------------------------------------------------------------------
// ifd_in_if
// Input sample channel: sample plus delay fraction, valid/ready.
// ---------------------------------------------------------------------------
`default_nettype none

interface ifd_in_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] input_sample;
    logic        [15:0]            delay_fraction;

    modport source (output valid, output input_sample, output delay_fraction, input ready);
    modport sink   (input valid, input input_sample, input delay_fraction, output ready);
endinterface

`default_nettype wire

/* sv/ifd_out_if.sv */
// ---------------------------------------------------------------------------
// ifd_out_if
// Output sample channel, valid/ready.
// ---------------------------------------------------------------------------
`default_nettype none

interface ifd_out_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] output_sample;

    modport source (output valid, output output_sample, input ready);
    modport sink   (input valid, input output_sample, output ready);
endinterface

`default_nettype wire

/* sv/ifd_cfg_if.sv */
// ---------------------------------------------------------------------------
// ifd_cfg_if
// Configuration write channel: register index and data, valid/ready.
// ---------------------------------------------------------------------------
`default_nettype none

interface ifd_cfg_if
    import ifd_pkg::*;
();

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [15:0]          data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* sv/ifd_store.sv */
// ---------------------------------------------------------------------------
// ifd_store
// Delay store: one write port, two read ports, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module ifd_store #(
    parameter int DEPTH       = 65536,
    parameter int SAMPLE_BITS = 24,
    parameter int AW          = $clog2(DEPTH)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_we,
    input  wire logic [AW-1:0]          i_waddr,
    input  wire logic [SAMPLE_BITS-1:0] i_wdata,
    input  wire logic [AW-1:0]          i_raddr0,
    input  wire logic [AW-1:0]          i_raddr1,
    output logic      [SAMPLE_BITS-1:0] o_rdata0,
    output logic      [SAMPLE_BITS-1:0] o_rdata1
);

    logic [SAMPLE_BITS-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end

endmodule

`default_nettype wire

/* sv/ifd_core.sv */
// ---------------------------------------------------------------------------
// ifd_core
// Sequencer and arithmetic: feedback write, read address, interpolation.
// ---------------------------------------------------------------------------
`default_nettype none

module ifd_core
    import ifd_pkg::*;
#(
    parameter int DEPTH       = 65536,
    parameter int SAMPLE_BITS = 24,
    parameter int AW          = $clog2(DEPTH)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cfg                   i_cfg,
    ifd_in_if.sink                      i_smp,
    ifd_out_if.source                   o_smp,
    output logic                        o_we,
    output logic      [AW-1:0]          o_waddr,
    output logic      [SAMPLE_BITS-1:0] o_wdata,
    output logic      [AW-1:0]          o_raddr0,
    output logic      [AW-1:0]          o_raddr1,
    input  wire logic [SAMPLE_BITS-1:0] i_rdata0,
    input  wire logic [SAMPLE_BITS-1:0] i_rdata1
);

    localparam int SB = SAMPLE_BITS;
    localparam int PW = AW + 17;
    localparam logic [AW:0]   DEPTH_C = (AW+1)'(DEPTH);
    localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);
    localparam logic [31:0]   DMAX32  = 32'(DEPTH - 1);
    localparam logic signed [SB+2:0] SMAX = {4'b0000, {(SB-1){1'b1}}};
    localparam logic signed [SB+2:0] SMIN = {4'b1111, {(SB-1){1'b0}}};

    function automatic logic [SB-1:0] sat(input logic signed [SB+2:0] v);
        logic [SB-1:0] res;
        if (v > SMAX) begin
            res = SMAX[SB-1:0];
        end else if (v < SMIN) begin
            res = SMIN[SB-1:0];
        end else begin
            res = v[SB-1:0];
        end
        return res;
    endfunction

    t_state r_state, n_state;

    logic                 r_out_valid;
    logic [SB-1:0]        r_out;
    logic [SB-1:0]        r_prev;
    logic [AW-1:0]        r_wp;
    logic                 r_full;
    logic [SB-1:0]        r_x;
    logic signed [SB+16:0] r_fbp;
    logic [PW-1:0]        r_off;
    logic [SB-1:0]        r_w;
    logic [15:0]          r_f;
    logic                 r_hit0, r_hit1, r_vld0, r_vld1;
    logic [SB-1:0]        r_a;
    logic signed [SB+17:0] r_prod;

    logic                 accept;
    logic                 done;
    logic [15:0]          dly_c;
    logic [15:0]          gain_c;
    logic [31:0]          off32;
    logic signed [SB:0]   fb;
    logic signed [SB+2:0] sum_w;
    logic [SB-1:0]        w;
    logic [PW-1:0]        pos;
    logic [AW:0]          ip;
    logic [AW-1:0]        i0, i1;
    logic [SB-1:0]        a, b;
    logic signed [SB:0]   diff;
    logic signed [SB+1:0] step;
    logic signed [SB+2:0] sum_y;
    logic [SB-1:0]        y;
    logic [AW-1:0]        wp_next;

    // next state and handshake
    always_comb begin
        n_state     = r_state;
        i_smp.ready = 1'b0;
        o_we        = 1'b0;
        done        = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                i_smp.ready = 1'b1;
                if (i_smp.valid) begin
                    n_state = S_ADDR;
                end
            end
            S_ADDR: begin
                o_we    = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || o_smp.ready) begin
                    done    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign accept = i_smp.valid && i_smp.ready;

    assign dly_c  = ({16'b0, i_cfg.delay_samples} > DMAX32) ? DMAX32[15:0]
                                                            : i_cfg.delay_samples;
    assign gain_c = (i_cfg.feedback_gain > GAIN_CAP) ? GAIN_CAP : i_cfg.feedback_gain;
    assign off32  = dly_c * i_smp.delay_fraction;

    // feedback and write value
    assign fb    = r_fbp[SB+16:16];
    assign sum_w = {{3{r_x[SB-1]}}, r_x} + {{2{fb[SB]}}, fb};
    assign w     = sat(sum_w);

    // read position, wrap by one compare
    assign pos = {({1'b0, r_wp} + DEPTH_C), 16'b0} - r_off;
    assign ip  = pos[PW-1:16];
    assign i0  = (ip >= DEPTH_C) ? AW'(ip - DEPTH_C) : ip[AW-1:0];
    assign i1  = (i0 == LAST) ? '0 : i0 + 1'b1;

    assign o_waddr  = r_wp;
    assign o_wdata  = w;
    assign o_raddr0 = i0;
    assign o_raddr1 = i1;

    // unwritten entries read zero, the entry just written is forwarded
    assign a    = r_hit0 ? r_w : (r_vld0 ? i_rdata0 : '0);
    assign b    = r_hit1 ? r_w : (r_vld1 ? i_rdata1 : '0);
    assign diff = {b[SB-1], b} - {a[SB-1], a};

    assign step  = r_prod[SB+17:16];
    assign sum_y = {{3{r_a[SB-1]}}, r_a} + {step[SB+1], step};
    assign y     = sat(sum_y);

    assign wp_next = (r_wp == LAST) ? '0 : r_wp + 1'b1;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x   <= i_smp.input_sample;
            r_fbp <= $signed(r_prev) * $signed({1'b0, gain_c});
            r_off <= PW'(off32);
        end
        if (r_state == S_ADDR) begin
            r_w    <= w;
            r_f    <= pos[15:0];
            r_hit0 <= (i0 == r_wp);
            r_hit1 <= (i1 == r_wp);
            r_vld0 <= r_full || (i0 <= r_wp);
            r_vld1 <= r_full || (i1 <= r_wp);
        end
        if (r_state == S_MUL) begin
            r_a    <= a;
            r_prod <= $signed({1'b0, r_f}) * diff;
        end
        if (done) begin
            r_out <= y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_prev      <= '0;
            r_wp        <= '0;
            r_full      <= 1'b0;
        end else begin
            if (done) begin
                r_out_valid <= 1'b1;
                r_prev      <= y;
                r_wp        <= wp_next;
                if (r_wp == LAST) begin
                    r_full <= 1'b1;
                end
            end else if (o_smp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_smp.valid         = r_out_valid;
    assign o_smp.output_sample = r_out;

    a_accept_to_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == S_ADDR)
        else $error("accepted request did not start the write cycle");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ADDR |-> ({1'b0, i0} < DEPTH_C) && ({1'b0, i1} < DEPTH_C))
        else $error("read address beyond store depth");

    a_read_neighbour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ADDR |-> (i1 == i0 + 1'b1) || ((i0 == LAST) && (i1 == '0)))
        else $error("second read is not the next entry");

    a_wp_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> r_wp == (($past(r_wp) == LAST) ? '0 : $past(r_wp) + 1'b1))
        else $error("write pointer did not advance by one");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> r_out_valid && (r_state == S_IDLE))
        else $error("finished request not presented");

endmodule

`default_nettype wire

/* sv/interpolated_feedback_delay.sv */
// ---------------------------------------------------------------------------
// interpolated_feedback_delay
// Feedback delay line with fractional read position and linear interpolation.
// ---------------------------------------------------------------------------
// Steps, one request at a time: accept and feedback multiply / store write
// and dual read / interpolation multiply / output. The output step waits
// while an earlier result is still unaccepted.
// A waiting result does not block acceptance: the next request is taken
// meanwhile and waits in its output step.
// Reset: synchronous, active low; pointer, feedback and registers cleared.
// No clearing pass: a fill pointer makes never-written entries read as zero.
`default_nettype none

module interpolated_feedback_delay
    import ifd_pkg::*;
#(
    parameter int DEPTH       = 65536,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ifd_in_if.sink    i_smp,
    ifd_out_if.source o_smp,
    ifd_cfg_if.sink   i_cfg
);

    localparam int AW = $clog2(DEPTH);

    t_cfg r_cfg;

    logic                   we;
    logic [AW-1:0]          waddr;
    logic [SAMPLE_BITS-1:0] wdata;
    logic [AW-1:0]          raddr0, raddr1;
    logic [SAMPLE_BITS-1:0] rdata0, rdata1;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delay_samples <= DELAY_RESET;
            r_cfg.feedback_gain <= GAIN_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                CFG_DELAY: r_cfg.delay_samples <= i_cfg.data;
                CFG_GAIN:  r_cfg.feedback_gain <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    ifd_core #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .AW          (AW)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_smp    (i_smp),
        .o_smp    (o_smp),
        .o_we     (we),
        .o_waddr  (waddr),
        .o_wdata  (wdata),
        .o_raddr0 (raddr0),
        .o_raddr1 (raddr1),
        .i_rdata0 (rdata0),
        .i_rdata1 (rdata1)
    );

    ifd_store #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .AW          (AW)
    ) u_store (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_waddr  (waddr),
        .i_wdata  (wdata),
        .i_raddr0 (raddr0),
        .i_raddr1 (raddr1),
        .o_rdata0 (rdata0),
        .o_rdata1 (rdata1)
    );

endmodule

`default_nettype wire

/* tb/testbench.sv */
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the interpolated feedback delay. Samples and delay
// fractions are pushed through the request channel with random gaps, results
// are drained with random back-pressure and one long hold-off. Each output is
// checked against a bit-true model of the store, feedback and interpolation.
// Register settings change between phases while the block is idle.
// ---------------------------------------------------------------------------
module testbench
    import ifd_pkg::*;
();

    localparam int DEPTH = 65536;
    localparam int SB    = 24;
    localparam int LIMIT = 500000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 4'd15;
    localparam logic signed [SB-1:0] SMP_MAX   = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SMP_MIN   = {1'b1, {(SB-1){1'b0}}};
    localparam longint               LIM_HI    = (longint'(1) <<< (SB-1)) - 1;
    localparam longint               LIM_LO    = -LIM_HI - 1;

    // Tracks the delay line and the echoes it must produce.
    class echo_tracker;
        logic signed [SB-1:0] store [DEPTH];
        int                   wp;
        longint               last_out;
        logic [15:0]          delay;
        logic [15:0]          gain;
        logic signed [SB-1:0] due_echoes [$];
        int                   n_taken;
        int                   errors;

        function new();
            foreach (store[i]) store[i] = '0;
            wp       = 0;
            last_out = 0;
            delay    = DELAY_RESET;
            gain     = GAIN_RESET;
            n_taken  = 0;
            errors   = 0;
        endfunction

        function longint fit_sample(longint v);
            if (v > LIM_HI) return LIM_HI;
            if (v < LIM_LO) return LIM_LO;
            return v;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
            if (idx == CFG_DELAY) delay = data;
            else if (idx == CFG_GAIN) gain = data;
        endfunction

        function void take_sample(logic signed [SB-1:0] smp, logic [15:0] frac);
            longint x, g, d, fb, w, pos, ip, fpart, a, b, y;
            int     i0, i1;
            x = smp;
            g = (gain > GAIN_CAP) ? longint'(GAIN_CAP) : longint'(gain);
            d = longint'(delay);
            if (d > DEPTH - 1) d = DEPTH - 1;
            fb = (last_out * g) >>> 16;
            w  = fit_sample(x + fb);
            store[wp] = w[SB-1:0];
            pos   = ((longint'(wp) + DEPTH) <<< 16) - d * longint'(frac);
            ip    = pos >>> 16;
            fpart = pos & 64'hFFFF;
            i0    = int'(ip % DEPTH);
            i1    = int'((ip + 1) % DEPTH);
            a     = store[i0];
            b     = store[i1];
            y     = fit_sample(a + ((fpart * (b - a)) >>> 16));
            last_out = y;
            wp       = (wp + 1) % DEPTH;
            due_echoes.push_back(y[SB-1:0]);
            n_taken++;
        endfunction

        function void check_echo(logic signed [SB-1:0] got);
            logic signed [SB-1:0] want;
            if (due_echoes.size() == 0) begin
                $display("%0t: output_sample %0d arrived with none expected", $time, got);
                errors++;
            end else begin
                want = due_echoes.pop_front();
                if (got !== want) begin
                    $display("%0t: output_sample expected %0d actual %0d", $time, want, got);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return due_echoes.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    ifd_in_if  #(.SAMPLE_BITS(SB)) smp_in ();
    ifd_out_if #(.SAMPLE_BITS(SB)) smp_out ();
    ifd_cfg_if                     cfg ();

    interpolated_feedback_delay #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SB)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_in),
        .o_smp   (smp_out),
        .i_cfg   (cfg)
    );

    echo_tracker echoes = new();

    int unsigned cycle_count = 0;
    int          hold_left   = 0;
    int          calm_left   = 0;
    int          gap_left    = 0;
    bit          held        = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("interpolated_feedback_delay: mismatch");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [SB-1:0] rand_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)  return SMP_MAX;
        if (r < 16) return SMP_MIN;
        if (r < 20) return '0;
        if (r < 24) return '1;
        return SB'($urandom());
    endfunction

    function automatic logic [15:0] rand_frac();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return 16'd0;
        if (r < 25) return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    // result side: random back-pressure plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            smp_out.ready <= 1'b0;
        end else begin
            if (smp_out.valid && smp_out.ready) echoes.check_echo(smp_out.output_sample);
            if (hold_left > 0) begin
                hold_left--;
                smp_out.ready <= 1'b0;
            end else if (!held && echoes.n_taken >= 150) begin
                held      = 1'b1;
                hold_left = 300;
                smp_out.ready <= 1'b0;
            end else if (calm_left > 0) begin
                calm_left--;
                smp_out.ready <= 1'b1;
            end else if (gap_left > 0) begin
                gap_left--;
                smp_out.ready <= 1'b0;
            end else begin
                smp_out.ready <= 1'b1;
                if ($urandom_range(0, 99) < 4) calm_left = 40;
                else gap_left = pick_gap();
            end
        end
    end

    task automatic send(input logic signed [SB-1:0] smp, input logic [15:0] frac,
                        input bit busy);
        int gap;
        smp_in.valid          <= 1'b1;
        smp_in.input_sample   <= smp;
        smp_in.delay_fraction <= frac;
        do @(posedge i_clk); while (!smp_in.ready);
        echoes.take_sample(smp, frac);
        gap = busy ? 0 : pick_gap();
        if (gap > 0) begin
            smp_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do @(posedge i_clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        echoes.set_reg(idx, data);
        @(posedge i_clk);
    endtask

    task automatic drain();
        smp_in.valid <= 1'b0;
        while (echoes.pending() > 0) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_delay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 16'($urandom_range(1, 16));
        if (r < 70) return 16'($urandom_range(17, 300));
        if (r < 80) return 16'd0;
        if (r < 90) return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [15:0] rand_gain();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return 16'd0;
        if (r < 40) return GAIN_CAP;
        if (r < 50) return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    initial begin
        bit busy;
        i_rst_n               <= 1'b0;
        smp_in.valid          <= 1'b0;
        smp_in.input_sample   <= '0;
        smp_in.delay_fraction <= '0;
        cfg.valid             <= 1'b0;
        cfg.index             <= CFG_DELAY;
        cfg.data              <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: zero offset reads back the stored sample
        send(SMP_MAX, 16'd0, 1'b0);
        send(SMP_MIN, 16'hFFFF, 1'b0);
        drain();

        // short delay, gain at its cap: feedback saturates
        write_reg(CFG_DELAY, 16'd3);
        write_reg(CFG_GAIN, GAIN_CAP);
        send(SMP_MAX, 16'd0, 1'b0);
        send(SMP_MAX, 16'hFFFF, 1'b0);
        send(SMP_MIN, 16'h8000, 1'b0);
        send('1, 16'd21845, 1'b0);
        send('0, 16'hFFFF, 1'b1);
        send(24'sd1, 16'd0, 1'b1);
        send(SMP_MIN, 16'd0, 1'b0);
        send(SMP_MIN, 16'd1, 1'b0);
        drain();

        // gain above the cap, zero delay
        write_reg(CFG_GAIN, 16'hFFFF);
        write_reg(CFG_DELAY, 16'd0);
        send(24'sd123456, 16'hFFFF, 1'b0);
        send(SMP_MIN, 16'd1, 1'b0);
        send(SMP_MAX, 16'd40000, 1'b0);
        drain();

        // longest delay, no feedback, write to an unused index ignored
        write_reg(CFG_DELAY, 16'hFFFF);
        write_reg(CFG_GAIN, 16'd0);
        write_reg(CFG_SPARE, 16'hFFFF);
        send(SMP_MAX, 16'hFFFF, 1'b0);
        send(SMP_MIN, 16'hFFFF, 1'b0);
        send(24'sh555555, 16'd1, 1'b0);
        send(24'shAAAAAA, 16'd0, 1'b0);
        drain();

        for (int p = 0; p < 8; p++) begin
            write_reg(CFG_DELAY, rand_delay());
            write_reg(CFG_GAIN, rand_gain());
            if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, 16'($urandom_range(0, 65535)));
            busy = ($urandom_range(0, 3) == 0);
            repeat (50) send(rand_sample(), rand_frac(), busy);
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (echoes.errors == 0 && echoes.pending() == 0) begin
            $display("interpolated_feedback_delay: match");
        end else begin
            $display("interpolated_feedback_delay: mismatch");
        end
        $finish;
    end

endmodule

/* files.f */
sv/ifd_pkg.sv
sv/ifd_in_if.sv
sv/ifd_out_if.sv
sv/ifd_cfg_if.sv
sv/ifd_store.sv
sv/ifd_core.sv
sv/interpolated_feedback_delay.sv
tb/testbench.sv
